FILE: rtl/core/psn_pkg.sv
// Package for the photometric stereo normal and albedo unit.
// Holds the fixed widths, register indexes and sideband structs of the pipeline.
// Depends on nothing; every other file of the block except psn_isqrt refers to it by scoped names.
package psn_pkg;

  localparam int PIX_W     = 8;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = COEF_W - 3;
  localparam int NUM_COEF  = 3;
  localparam int NUM_REGS  = 4;
  localparam int PROD_W    = PIX_W + COEF_W;
  localparam int G_W       = PROD_W + 2;
  localparam int A_W       = G_W - 1;
  localparam int SQ_W      = 2 * A_W;
  localparam int S_W       = SQ_W + 2;
  localparam int MSB_W     = 6;
  localparam int T_W       = 62;
  localparam int ROOT_W    = T_W / 2;
  localparam int K_W       = 5;
  localparam int ALB_W     = 17;
  localparam int ALB_SHIFT = FRAC_W - 4;
  localparam int NRM_W     = 16;
  localparam int NUM_W     = 47;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int Q_W       = 15;
  localparam int NUM_SHIFT = 15;
  localparam int NST       = 6 + ROOT_W + 1 + Q_W + 1;

  localparam int LIGHTS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = NUM_COEF * COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_LIGHTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = 3'd4;
  localparam logic [LIGHTS_W-1:0]  LIGHTS_RESET   = 3'd3;

  localparam logic [ALB_W-1:0] ALB_MAX   = '1;
  localparam logic [Q_W-1:0]   UNIT_Q14  = 15'd16384;
  localparam logic [MSB_W:0]   TOP_BIT   = 7'd61;

  typedef struct packed {
    logic                              z;
    logic [K_W-1:0]                    k;
    logic [NUM_COEF-1:0]               sg;
    logic [NUM_COEF-1:0][A_W-1:0]      a;
  } rt_side_t;

  typedef struct packed {
    logic                z;
    logic [NUM_COEF-1:0] sg;
    logic [ALB_W-1:0]    alb;
  } dv_side_t;

endpackage

FILE: rtl/core/psn_stream_if.sv
// Stream interfaces of the photometric stereo unit: pixel beats in, result beats out.
// Depends on psn_pkg for field widths.
interface psn_pix_if;
  logic                         valid;
  logic                         ready;
  logic [psn_pkg::PIX_W-1:0]    intensity_a;
  logic [psn_pkg::PIX_W-1:0]    intensity_b;
  logic [psn_pkg::PIX_W-1:0]    intensity_c;
  logic [psn_pkg::PIX_W-1:0]    intensity_d;
  modport source (output valid, intensity_a, intensity_b, intensity_c, intensity_d,
                  input ready);
  modport sink (input valid, intensity_a, intensity_b, intensity_c, intensity_d,
                output ready);
endinterface

interface psn_res_if;
  logic                              valid;
  logic                              ready;
  logic [psn_pkg::ALB_W-1:0]         albedo;
  logic signed [psn_pkg::NRM_W-1:0]  normal_x;
  logic signed [psn_pkg::NRM_W-1:0]  normal_y;
  logic signed [psn_pkg::NRM_W-1:0]  normal_z;
  logic                              zero_magnitude;
  modport source (output valid, albedo, normal_x, normal_y, normal_z, zero_magnitude,
                  input ready);
  modport sink (input valid, albedo, normal_x, normal_y, normal_z, zero_magnitude,
                output ready);
endinterface

FILE: rtl/core/psn_lane.sv
// One light lane: multiplies the light's intensity by its three coefficients, or yields zero for an inactive light.
// Depends on psn_pkg.
module psn_lane (
  input  logic                                  clk,
  input  logic                                  ld,
  input  logic                                  active,
  input  logic [psn_pkg::PIX_W-1:0]             pix,
  input  logic [psn_pkg::CFG_W-1:0]             coef,
  output logic signed [psn_pkg::PROD_W-1:0]     prod_r [psn_pkg::NUM_COEF]
);

  logic signed [psn_pkg::PROD_W:0]   prod_nxt [psn_pkg::NUM_COEF];
  logic signed [psn_pkg::COEF_W-1:0] c        [psn_pkg::NUM_COEF];

  always_comb begin
    for (int j = 0; j < psn_pkg::NUM_COEF; j++) begin
      c[j]        = $signed(coef[j*psn_pkg::COEF_W +: psn_pkg::COEF_W]);
      prod_nxt[j] = $signed({1'b0, pix}) * c[j];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      for (int j = 0; j < psn_pkg::NUM_COEF; j++) begin
        prod_r[j] <= active ? prod_nxt[j][psn_pkg::PROD_W-1:0] : '0;
      end
    end
  end

endmodule

FILE: rtl/core/psn_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband carried along.
// Depends on psn_pkg only through the widths that the top level passes in.
module psn_isqrt #(
  parameter int RAD_W  = 62,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [RAD_W-1:0]      rad,
  input  logic [SIDE_W-1:0]     side_in,
  output logic [RAD_W/2-1:0]    root,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] sd;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign sd      = side_in;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign sd      = side_r[i-1];
    end

    assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (cur - trial) : cur;
        root_r[i] <= {root_in[ROOT_W-2:0], ge};
        rad_r[i]  <= rad_in << 2;
        side_r[i] <= sd;
      end
    end
  end

  assign root     = root_r[ROOT_W-1];
  assign side_out = side_r[ROOT_W-1];

endmodule

FILE: rtl/core/psn_div.sv
// Pipelined restoring divider for the three normal components over one shared divisor.
// One quotient bit per stage; depends on psn_pkg for the component count.
module psn_div #(
  parameter int NUM_W  = 47,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 15,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num [psn_pkg::NUM_COEF],
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [Q_W-1:0]    quo [psn_pkg::NUM_COEF],
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W-1:0]  rem_r  [Q_W][psn_pkg::NUM_COEF];
  logic [Q_W-1:0]    q_r    [Q_W][psn_pkg::NUM_COEF];
  logic [DEN_W-1:0]  den_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] sd;
    logic [NUM_W-1:0]  dsh;

    if (i == 0) begin : g_first
      assign den_in = den;
      assign sd     = side_in;
    end else begin : g_next
      assign den_in = den_r[i-1];
      assign sd     = side_r[i-1];
    end

    assign dsh = NUM_W'(den_in) << (Q_W - 1 - i);

    for (genvar l = 0; l < psn_pkg::NUM_COEF; l++) begin : g_comp
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   q_in;
      logic             ge;

      if (i == 0) begin : g_first
        assign rem_in = num[l];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[i-1][l];
        assign q_in   = q_r[i-1][l];
      end

      assign ge = (rem_in >= dsh);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i][l] <= ge ? (rem_in - dsh) : rem_in;
          q_r[i][l]   <= {q_in[Q_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i]  <= den_in;
        side_r[i] <= sd;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < psn_pkg::NUM_COEF; l++) begin
      quo[l] = q_r[Q_W-1][l];
    end
  end
  assign side_out = side_r[Q_W-1];

endmodule

FILE: rtl/core/photometric_stereo_normal_albedo_unit.sv
// Photometric stereo unit: per pixel it returns the albedo |g| (Q13.4, saturating) and the
// unit normal g/|g| (Q1.14), where g is the sum of intensity times coefficient over the lights.
// Depends on psn_pkg, psn_stream_if, psn_lane, psn_isqrt and psn_div.
//
// The unit takes one pixel beat per clock while the output is not stalled; each beat passes
// through one stage of light lanes, a merging adder, squaring, summing, two
// normalizing stages, a 31-stage square root that yields one root bit per stage, a preparation
// stage, a 15-stage divider that yields one quotient bit per stage for all three components,
// and the output register. When the output is stalled the whole pipeline holds; an empty first
// stage still takes a beat. Coefficients and the light count are read by the first stage.
module photometric_stereo_normal_albedo_unit #(
  parameter int MAX_LIGHTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  psn_pix_if.sink                           in_if,
  psn_res_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [psn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psn_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int NC = psn_pkg::NUM_COEF;

  logic [psn_pkg::LIGHTS_W-1:0] num_lights_r;
  logic [psn_pkg::CFG_W-1:0]    coef_r [psn_pkg::NUM_REGS];
  logic [psn_pkg::CFG_IDX_W-1:0] coef_idx;

  logic [psn_pkg::NST-1:0] v_r;
  logic en;
  logic in_ready;

  logic [psn_pkg::PIX_W-1:0]         pix [psn_pkg::NUM_REGS];
  logic signed [psn_pkg::PROD_W-1:0] prod [MAX_LIGHTS][NC];

  logic signed [psn_pkg::G_W-1:0] gsum [NC];
  logic [psn_pkg::A_W-1:0]        a1_r [NC];
  logic [NC-1:0]                  sg1_r;
  logic [psn_pkg::SQ_W-1:0]       sq2_r [NC];
  logic [psn_pkg::A_W-1:0]        a2_r [NC];
  logic [NC-1:0]                  sg2_r;
  logic [psn_pkg::S_W-1:0]        s3_r;
  logic [psn_pkg::A_W-1:0]        a3_r [NC];
  logic [NC-1:0]                  sg3_r;
  logic [psn_pkg::S_W-1:0]        s4_r;
  psn_pkg::rt_side_t              rt4_r;
  logic [psn_pkg::MSB_W-1:0]      msb;
  logic [psn_pkg::K_W-1:0]        kc;
  logic [psn_pkg::T_W-1:0]        t5_r;
  psn_pkg::rt_side_t              rt5_r;

  logic [psn_pkg::ROOT_W-1:0]     m;
  psn_pkg::rt_side_t              rt_o;
  logic [psn_pkg::ROOT_W-1:0]     msh;
  logic [psn_pkg::NUM_W-1:0]      numc [NC];
  logic [psn_pkg::NUM_W-1:0]      num_r [NC];
  logic [psn_pkg::DEN_W-1:0]      den_r;
  psn_pkg::dv_side_t              dv_r;
  logic [psn_pkg::Q_W-1:0]        quo [NC];
  psn_pkg::dv_side_t              dv_o;
  logic [psn_pkg::Q_W-1:0]        qc [NC];
  logic signed [psn_pkg::NRM_W-1:0] nrm [NC];

  logic [psn_pkg::ALB_W-1:0]        albedo_r;
  logic signed [psn_pkg::NRM_W-1:0] nx_r, ny_r, nz_r;
  logic                             zero_r;

  // Configuration registers.
  assign coef_idx = cfg_index - psn_pkg::REG_COEF_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_lights_r <= psn_pkg::LIGHTS_RESET;
      for (int i = 0; i < psn_pkg::NUM_REGS; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      priority if (cfg_index == psn_pkg::REG_NUM_LIGHTS) begin
        num_lights_r <= cfg_wdata[psn_pkg::LIGHTS_W-1:0];
      end else if (cfg_index >= psn_pkg::REG_COEF_FIRST &&
                   cfg_index <= psn_pkg::REG_COEF_LAST) begin
        coef_r[coef_idx[1:0]] <= cfg_wdata;
      end
    end
  end

  // Pipeline control.
  assign en       = !v_r[psn_pkg::NST-1] || out_if.ready;
  assign in_ready = en || !v_r[0];
  assign in_if.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (in_ready) v_r[0] <= in_if.valid;
      if (en) v_r[psn_pkg::NST-1:1] <= v_r[psn_pkg::NST-2:0];
    end
  end

  // Light lanes.
  assign pix[0] = in_if.intensity_a;
  assign pix[1] = in_if.intensity_b;
  assign pix[2] = in_if.intensity_c;
  assign pix[3] = in_if.intensity_d;

  for (genvar i = 0; i < MAX_LIGHTS; i++) begin : g_lane
    psn_lane u_lane (
      .clk    (clk),
      .ld     (in_ready),
      .active (psn_pkg::LIGHTS_W'(i) < num_lights_r),
      .pix    (pix[i]),
      .coef   (coef_r[i]),
      .prod_r (prod[i])
    );
  end

  // Merge the lanes into g and take magnitudes.
  always_comb begin
    for (int j = 0; j < NC; j++) begin
      gsum[j] = '0;
      for (int i = 0; i < MAX_LIGHTS; i++) begin
        gsum[j] = gsum[j] + psn_pkg::G_W'(prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NC; j++) begin
        sg1_r[j] <= gsum[j][psn_pkg::G_W-1];
        a1_r[j]  <= gsum[j][psn_pkg::G_W-1] ? psn_pkg::A_W'(-gsum[j])
                                            : psn_pkg::A_W'(gsum[j]);
        sq2_r[j] <= a1_r[j] * a1_r[j];
        a2_r[j]  <= a1_r[j];
        a3_r[j]  <= a2_r[j];
      end
      sg2_r <= sg1_r;
      sg3_r <= sg2_r;
      s3_r  <= psn_pkg::S_W'(sq2_r[0]) + psn_pkg::S_W'(sq2_r[1]) + psn_pkg::S_W'(sq2_r[2]);
    end
  end

  // Normalize the sum of squares into the top two bits of the root input.
  always_comb begin
    msb = '0;
    for (int p = 0; p < psn_pkg::S_W; p++) begin
      if (s3_r[p]) msb = psn_pkg::MSB_W'(p);
    end
    kc = psn_pkg::K_W'((psn_pkg::TOP_BIT - {1'b0, msb}) >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r     <= s3_r;
      rt4_r.z  <= (s3_r == '0);
      rt4_r.k  <= kc;
      rt4_r.sg <= sg3_r;
      for (int j = 0; j < NC; j++) rt4_r.a[j] <= a3_r[j];
      t5_r     <= psn_pkg::T_W'(s4_r) << {rt4_r.k, 1'b0};
      rt5_r    <= rt4_r;
    end
  end

  psn_isqrt #(
    .RAD_W  (psn_pkg::T_W),
    .SIDE_W ($bits(psn_pkg::rt_side_t))
  ) u_isqrt (
    .clk      (clk),
    .en       (en),
    .rad      (t5_r),
    .side_in  (rt5_r),
    .root     (m),
    .side_out (rt_o)
  );

  // Albedo and divider operands.
  assign msh = m >> (rt_o.k + psn_pkg::ALB_SHIFT);

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      numc[j] = (psn_pkg::NUM_W'(rt_o.a[j]) << (rt_o.k + psn_pkg::NUM_SHIFT))
                + psn_pkg::NUM_W'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NC; j++) num_r[j] <= numc[j];
      den_r  <= {m, 1'b0};
      dv_r.z <= rt_o.z;
      dv_r.sg <= rt_o.sg;
      dv_r.alb <= (msh > psn_pkg::ROOT_W'(psn_pkg::ALB_MAX)) ? psn_pkg::ALB_MAX
                                                             : msh[psn_pkg::ALB_W-1:0];
    end
  end

  psn_div #(
    .NUM_W  (psn_pkg::NUM_W),
    .DEN_W  (psn_pkg::DEN_W),
    .Q_W    (psn_pkg::Q_W),
    .SIDE_W ($bits(psn_pkg::dv_side_t))
  ) u_div (
    .clk      (clk),
    .en       (en),
    .num      (num_r),
    .den      (den_r),
    .side_in  (dv_r),
    .quo      (quo),
    .side_out (dv_o)
  );

  // Clamp, sign and output register.
  always_comb begin
    for (int j = 0; j < NC; j++) begin
      qc[j]  = (quo[j] > psn_pkg::UNIT_Q14) ? psn_pkg::UNIT_Q14 : quo[j];
      nrm[j] = dv_o.sg[j] ? -$signed(psn_pkg::NRM_W'(qc[j]))
                          : $signed(psn_pkg::NRM_W'(qc[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      albedo_r <= dv_o.z ? '0 : dv_o.alb;
      nx_r     <= dv_o.z ? '0 : nrm[0];
      ny_r     <= dv_o.z ? '0 : nrm[1];
      nz_r     <= dv_o.z ? '0 : nrm[2];
      zero_r   <= dv_o.z;
    end
  end

  assign out_if.valid          = v_r[psn_pkg::NST-1];
  assign out_if.albedo         = albedo_r;
  assign out_if.normal_x       = nx_r;
  assign out_if.normal_y       = ny_r;
  assign out_if.normal_z       = nz_r;
  assign out_if.zero_magnitude = zero_r;

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input not ready while the output register is empty");

  a_zero_clears_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.zero_magnitude |->
      out_if.albedo == '0 && out_if.normal_x == '0 &&
      out_if.normal_y == '0 && out_if.normal_z == '0)
    else $error("zero magnitude beat carries a nonzero field");

  a_normal_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |->
      out_if.normal_x <= 16'sd16384 && out_if.normal_x >= -16'sd16384 &&
      out_if.normal_y <= 16'sd16384 && out_if.normal_y >= -16'sd16384 &&
      out_if.normal_z <= 16'sd16384 && out_if.normal_z >= -16'sd16384)
    else $error("normal component beyond unit range");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_if.valid)
    else $error("result beat presented right after reset");

endmodule
